@@ hdl/hrqa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the heart rate qualifier and alarm block.
// No dependencies; every other file of the block refers to this package by scoped names.

package hrqa_pkg;

	localparam int TimeW    = 32;
	localparam int BpmW     = 9;
	localparam int RateW    = 8;
	localparam int Spo2W    = 8;
	localparam int AdcW     = 12;
	localparam int TempW    = 9;
	localparam int HoldW    = 16;
	localparam int CntW     = 2;
	localparam int Spo2LimW = 7;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int FlagW    = 6;
	localparam int MixW     = 12;

	localparam int FlagBrady       = 0;
	localparam int FlagTachy       = 1;
	localparam int FlagHypoxia     = 2;
	localparam int FlagFever       = 3;
	localparam int FlagHypothermia = 4;
	localparam int FlagNoPulse     = 5;

	localparam logic signed [BpmW-1:0]  BpmMin     = 9'sd25;
	localparam logic signed [BpmW-1:0]  BpmMax     = 9'sd220;
	localparam logic signed [BpmW-1:0]  BpmNone    = -9'sd1;
	localparam logic signed [Spo2W-1:0] Spo2Min    = 8'sd70;
	localparam logic signed [Spo2W-1:0] Spo2Max    = 8'sd100;
	localparam logic signed [Spo2W-1:0] Spo2None   = -8'sd1;
	localparam logic [TempW-1:0]        TempBase   = 9'd340;
	localparam logic [TempW-1:0]        TempTop    = 9'd400;
	localparam logic [TempW-1:0]        TempReset  = 9'd365;
	localparam logic [AdcW-1:0]         AdcFull    = 12'd4095;
	localparam logic [TimeW-1:0]        EvalPeriod = 32'd10;
	localparam logic [TimeW-1:0]        ToggleGap  = 32'd150;

	localparam logic [RateW-1:0]    RstBpmTol   = 8'd10;
	localparam logic [CntW-1:0]     RstConfirm  = 2'd3;
	localparam logic [RateW-1:0]    RstBrady    = 8'd50;
	localparam logic [RateW-1:0]    RstTachy    = 8'd120;
	localparam logic [Spo2LimW-1:0] RstHypoxia  = 7'd90;
	localparam logic [TempW-1:0]    RstFever    = 9'd385;
	localparam logic [TempW-1:0]    RstHypother = 9'd355;
	localparam logic [HoldW-1:0]    RstHold     = 16'd5000;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BPM_TOL,
		CFG_CONFIRM,
		CFG_BRADY,
		CFG_TACHY,
		CFG_HYPOXIA,
		CFG_FEVER,
		CFG_HYPOTHERMIA,
		CFG_HOLD
	} cfg_idx_t;

	typedef struct packed {
		logic [RateW-1:0]    bpm_tolerance;
		logic [CntW-1:0]     confirmations_needed;
		logic [RateW-1:0]    brady_limit;
		logic [RateW-1:0]    tachy_limit;
		logic [Spo2LimW-1:0] hypoxia_limit;
		logic [TempW-1:0]    fever_limit_tenths;
		logic [TempW-1:0]    hypothermia_limit_tenths;
		logic [HoldW-1:0]    critical_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0]        now_ms;
		logic signed [BpmW-1:0]  bpm_reading;
		logic                    finger_present;
		logic signed [Spo2W-1:0] spo2_reading;
		logic [AdcW-1:0]         temp_adc;
	} item_t;

	typedef struct packed {
		logic [RateW-1:0]        heart_rate;
		logic signed [Spo2W-1:0] spo2_value;
		logic [TempW-1:0]        temp_tenths;
		logic                    buzzer_on;
		logic                    rate_confirmed;
		logic [FlagW-1:0]        flags;
	} result_t;

	// Quotient by ten through a reciprocal; exact for every input below 2560, as the quotient has eight bits.
	function automatic logic [RateW-1:0] div10(input logic [MixW-1:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'd6554;
		return p[23:16];
	endfunction

	// Scales a raw sample to tenths of a degree: adc * 60 / 4095 + 340, truncated.
	function automatic logic [TempW-1:0] temp_scale(input logic [AdcW-1:0] adc);
		logic [17:0] x;
		logic [5:0]  q;
		logic [12:0] r;
		x = 18'(adc) * 18'd60;
		q = x[17:12];
		r = 13'(x[11:0]) + 13'(q);
		if (r >= 13'(AdcFull)) begin
			q = q + 6'd1;
		end
		return 9'(q) + TempBase;
	endfunction

endpackage

@@ hdl/hrqa_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pulse item, result and register write channels.
// Depends on hrqa_pkg for field widths.

interface hrqa_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [hrqa_pkg::TimeW-1:0]            now_ms;
	logic signed [hrqa_pkg::BpmW-1:0]      bpm_reading;
	logic                                  finger_present;
	logic signed [hrqa_pkg::Spo2W-1:0]     spo2_reading;
	logic [hrqa_pkg::AdcW-1:0]             temp_adc;

	modport source(output valid, now_ms, bpm_reading, finger_present, spo2_reading, temp_adc,
		input ready);
	modport sink(input valid, now_ms, bpm_reading, finger_present, spo2_reading, temp_adc,
		output ready);
endinterface

interface hrqa_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [hrqa_pkg::RateW-1:0]            heart_rate;
	logic signed [hrqa_pkg::Spo2W-1:0]     spo2_value;
	logic [hrqa_pkg::TempW-1:0]            temp_tenths;
	logic                                  buzzer_on;
	logic                                  rate_confirmed;
	logic                                  brady_alarm;
	logic                                  tachy_alarm;
	logic                                  hypoxia_alarm;
	logic                                  fever_alarm;
	logic                                  hypothermia_alarm;
	logic                                  no_pulse_alarm;

	modport source(output valid, heart_rate, spo2_value, temp_tenths, buzzer_on, rate_confirmed,
		brady_alarm, tachy_alarm, hypoxia_alarm, fever_alarm, hypothermia_alarm, no_pulse_alarm,
		input ready);
	modport sink(input valid, heart_rate, spo2_value, temp_tenths, buzzer_on, rate_confirmed,
		brady_alarm, tachy_alarm, hypoxia_alarm, fever_alarm, hypothermia_alarm, no_pulse_alarm,
		output ready);
endinterface

interface hrqa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hrqa_pkg::CfgIdxW-1:0]    index;
	logic [hrqa_pkg::CfgDataW-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/hrqa_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file; each write beat updates one threshold register.
// Depends on hrqa_pkg and the hrqa_cfg_if interface.

module hrqa_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	hrqa_cfg_if.sink          wr,
	output hrqa_pkg::cfg_t    cfg
);

	hrqa_pkg::cfg_t cfg_q;
	hrqa_pkg::cfg_idx_t idx;

	assign wr.ready = 1'b1;
	assign idx = hrqa_pkg::cfg_idx_t'(wr.index);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpm_tolerance            <= hrqa_pkg::RstBpmTol;
			cfg_q.confirmations_needed     <= hrqa_pkg::RstConfirm;
			cfg_q.brady_limit              <= hrqa_pkg::RstBrady;
			cfg_q.tachy_limit              <= hrqa_pkg::RstTachy;
			cfg_q.hypoxia_limit            <= hrqa_pkg::RstHypoxia;
			cfg_q.fever_limit_tenths       <= hrqa_pkg::RstFever;
			cfg_q.hypothermia_limit_tenths <= hrqa_pkg::RstHypother;
			cfg_q.critical_hold_ms         <= hrqa_pkg::RstHold;
		end else if (wr.valid) begin
			unique case (idx)
				hrqa_pkg::CFG_BPM_TOL:     cfg_q.bpm_tolerance <= wr.data[hrqa_pkg::RateW-1:0];
				hrqa_pkg::CFG_CONFIRM:     cfg_q.confirmations_needed <= wr.data[hrqa_pkg::CntW-1:0];
				hrqa_pkg::CFG_BRADY:       cfg_q.brady_limit <= wr.data[hrqa_pkg::RateW-1:0];
				hrqa_pkg::CFG_TACHY:       cfg_q.tachy_limit <= wr.data[hrqa_pkg::RateW-1:0];
				hrqa_pkg::CFG_HYPOXIA:     cfg_q.hypoxia_limit <= wr.data[hrqa_pkg::Spo2LimW-1:0];
				hrqa_pkg::CFG_FEVER:       cfg_q.fever_limit_tenths <= wr.data[hrqa_pkg::TempW-1:0];
				hrqa_pkg::CFG_HYPOTHERMIA: begin
					cfg_q.hypothermia_limit_tenths <= wr.data[hrqa_pkg::TempW-1:0];
				end
				hrqa_pkg::CFG_HOLD:        cfg_q.critical_hold_ms <= wr.data;
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

@@ hdl/hrqa_core.sv @@
`timescale 1ns / 1ps
// Per-beat state update: rate qualification, smoothing, 10 ms evaluation, alarms and buzzer.
// Depends on hrqa_pkg; the state advances only on beats presented with fire high.

module hrqa_core (
	input  logic                clk,
	input  logic                arst_n,
	input  hrqa_pkg::cfg_t      cfg,
	input  logic                fire,
	input  hrqa_pkg::item_t     item,
	output hrqa_pkg::result_t   res
);

	localparam int TW = hrqa_pkg::TimeW;
	localparam int RW = hrqa_pkg::RateW;

	logic [RW-1:0]                    cand_q, smooth_q;
	logic [hrqa_pkg::CntW-1:0]        cnt_q;
	logic [TW-1:0]                    last_valid_q, crit_start_q, next_eval_q, last_toggle_q;
	logic                             latch_q, phase_q, buzz_q;
	logic signed [hrqa_pkg::Spo2W-1:0] spo2_q;
	logic [hrqa_pkg::TempW-1:0]       temp_q;
	logic [hrqa_pkg::FlagW-1:0]       flags_q;

	logic [RW-1:0]                    cand_n, smooth_n;
	logic [hrqa_pkg::CntW-1:0]        cnt_n;
	logic signed [hrqa_pkg::BpmW-1:0] instant_n;
	logic [TW-1:0]                    last_valid_n, crit_start_n, next_eval_n, last_toggle_n;
	logic                             latch_n, phase_n, buzz_n;
	logic signed [hrqa_pkg::Spo2W-1:0] spo2_n;
	logic [hrqa_pkg::TempW-1:0]       temp_n;
	logic [hrqa_pkg::FlagW-1:0]       flags_n;

	logic [RW-1:0]   rd, diff;
	logic            rd_ok, restart, eval, out_of_range, no_valid;
	logic [TW-1:0]   hold;

	always_comb begin
		cand_n        = cand_q;
		smooth_n      = smooth_q;
		cnt_n         = cnt_q;
		instant_n     = item.bpm_reading;
		last_valid_n  = last_valid_q;
		crit_start_n  = crit_start_q;
		next_eval_n   = next_eval_q;
		last_toggle_n = last_toggle_q;
		latch_n       = latch_q;
		phase_n       = phase_q;
		buzz_n        = buzz_q;
		spo2_n        = spo2_q;
		temp_n        = temp_q;
		flags_n       = flags_q;
		out_of_range  = 1'b0;
		no_valid      = 1'b0;

		hold    = TW'(cfg.critical_hold_ms);
		rd      = item.bpm_reading[RW-1:0];
		rd_ok   = (item.bpm_reading >= hrqa_pkg::BpmMin) && (item.bpm_reading <= hrqa_pkg::BpmMax);
		diff    = (rd > cand_q) ? (rd - cand_q) : (cand_q - rd);
		restart = (cand_q == '0) || (diff > cfg.bpm_tolerance);
		eval    = (item.now_ms - next_eval_q) >= hrqa_pkg::EvalPeriod;

		if (rd_ok) begin
			last_valid_n = item.now_ms;
			if (restart) begin
				cand_n = rd;
				cnt_n  = hrqa_pkg::CntW'(1);
			end else begin
				cand_n = hrqa_pkg::div10(hrqa_pkg::MixW'(cand_q) * 12'd7
					+ hrqa_pkg::MixW'(rd) * 12'd3);
				if (cnt_q < cfg.confirmations_needed) begin
					cnt_n = cnt_q + hrqa_pkg::CntW'(1);
				end
			end
			if (cnt_n >= cfg.confirmations_needed) begin
				if (smooth_q == '0) begin
					smooth_n = cand_n;
				end else begin
					smooth_n = hrqa_pkg::div10(hrqa_pkg::MixW'(smooth_q) * 12'd8
						+ hrqa_pkg::MixW'(cand_n) * 12'd2);
				end
			end
		end

		if (!item.finger_present) begin
			smooth_n     = '0;
			instant_n    = hrqa_pkg::BpmNone;
			cand_n       = '0;
			cnt_n        = '0;
			last_valid_n = '0;
			crit_start_n = '0;
			latch_n      = 1'b0;
		end

		if (eval) begin
			next_eval_n = next_eval_q + hrqa_pkg::EvalPeriod;
			spo2_n = ((item.spo2_reading >= hrqa_pkg::Spo2Min)
				&& (item.spo2_reading <= hrqa_pkg::Spo2Max)) ? item.spo2_reading : hrqa_pkg::Spo2None;
			temp_n = hrqa_pkg::temp_scale(item.temp_adc);

			out_of_range = (instant_n >= hrqa_pkg::BpmMin)
				&& ((instant_n[RW-1:0] < cfg.brady_limit) || (instant_n[RW-1:0] > cfg.tachy_limit));
			no_valid = item.finger_present && (last_valid_n != '0)
				&& ((item.now_ms - last_valid_n) >= hold);
			if (out_of_range || no_valid) begin
				if (crit_start_n == '0) begin
					crit_start_n = item.now_ms;
				end
				if ((item.now_ms - crit_start_n) >= hold) begin
					latch_n = 1'b1;
				end
			end else begin
				crit_start_n = '0;
				latch_n      = 1'b0;
			end

			flags_n = '0;
			flags_n[hrqa_pkg::FlagBrady] = latch_n && (smooth_n != '0)
				&& (smooth_n < cfg.brady_limit);
			flags_n[hrqa_pkg::FlagTachy] = latch_n && (smooth_n > cfg.tachy_limit);
			flags_n[hrqa_pkg::FlagHypoxia] = (spo2_n > 8'sd0)
				&& (spo2_n < $signed({1'b0, cfg.hypoxia_limit}));
			flags_n[hrqa_pkg::FlagFever] = temp_n > cfg.fever_limit_tenths;
			flags_n[hrqa_pkg::FlagHypothermia] = temp_n < cfg.hypothermia_limit_tenths;
			flags_n[hrqa_pkg::FlagNoPulse] = item.finger_present && (smooth_n == '0);

			if (|flags_n) begin
				if ((item.now_ms - last_toggle_q) > hrqa_pkg::ToggleGap) begin
					phase_n       = !phase_q;
					buzz_n        = phase_n;
					last_toggle_n = item.now_ms;
				end
			end else begin
				buzz_n = 1'b0;
			end
		end
	end

	always_comb begin
		res.heart_rate     = smooth_n;
		res.spo2_value     = spo2_n;
		res.temp_tenths    = temp_n;
		res.buzzer_on      = buzz_n;
		res.rate_confirmed = latch_n;
		res.flags          = flags_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q        <= '0;
			smooth_q      <= '0;
			cnt_q         <= '0;
			last_valid_q  <= '0;
			crit_start_q  <= '0;
			next_eval_q   <= '0;
			last_toggle_q <= '0;
			latch_q       <= 1'b0;
			phase_q       <= 1'b0;
			buzz_q        <= 1'b0;
			spo2_q        <= hrqa_pkg::Spo2None;
			temp_q        <= hrqa_pkg::TempReset;
			flags_q       <= '0;
		end else if (fire) begin
			cand_q        <= cand_n;
			smooth_q      <= smooth_n;
			cnt_q         <= cnt_n;
			last_valid_q  <= last_valid_n;
			crit_start_q  <= crit_start_n;
			next_eval_q   <= next_eval_n;
			last_toggle_q <= last_toggle_n;
			latch_q       <= latch_n;
			phase_q       <= phase_n;
			buzz_q        <= buzz_n;
			spo2_q        <= spo2_n;
			temp_q        <= temp_n;
			flags_q       <= flags_n;
		end
	end

endmodule

@@ hdl/heart_rate_qualifier_alarm.sv @@
`timescale 1ns / 1ps
// Top level of the heart rate qualifier and alarm block.
// Depends on hrqa_pkg, the channel interfaces, hrqa_cfg_regs and hrqa_core.

// The block takes one pulse beat per clock cycle while its results are taken and returns one
// result beat for each. A beat is first held in an input register; once the result register
// can take it, the whole state update (rate qualification, smoothing, 10 ms evaluation, alarms,
// buzzer) is done in one pass and written to the result register, and a stalled result only
// blocks intake once both registers are full. The sustained rate is one beat per cycle, set by
// the state loop in the core. Register writes are always ready and take effect in the next
// cycle; they are meant to be issued while the block is idle.

module heart_rate_qualifier_alarm (
	input  logic            clk,
	input  logic            arst_n,
	hrqa_item_if.sink       item,
	hrqa_result_if.source   result,
	hrqa_cfg_if.sink        cfg
);

	hrqa_pkg::cfg_t     cfg_regs;
	hrqa_pkg::item_t    item_s1;
	hrqa_pkg::result_t  core_res;
	hrqa_pkg::result_t  res_s2;
	logic               valid_s1, valid_s2, advance, take;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	hrqa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg    (cfg_regs)
	);

	hrqa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_regs),
		.fire   (advance),
		.item   (item_s1),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			valid_s2 <= advance || (valid_s2 && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.now_ms         <= item.now_ms;
			item_s1.bpm_reading    <= item.bpm_reading;
			item_s1.finger_present <= item.finger_present;
			item_s1.spo2_reading   <= item.spo2_reading;
			item_s1.temp_adc       <= item.temp_adc;
		end
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid             = valid_s2;
	assign result.heart_rate        = res_s2.heart_rate;
	assign result.spo2_value        = res_s2.spo2_value;
	assign result.temp_tenths       = res_s2.temp_tenths;
	assign result.buzzer_on         = res_s2.buzzer_on;
	assign result.rate_confirmed    = res_s2.rate_confirmed;
	assign result.brady_alarm       = res_s2.flags[hrqa_pkg::FlagBrady];
	assign result.tachy_alarm       = res_s2.flags[hrqa_pkg::FlagTachy];
	assign result.hypoxia_alarm     = res_s2.flags[hrqa_pkg::FlagHypoxia];
	assign result.fever_alarm       = res_s2.flags[hrqa_pkg::FlagFever];
	assign result.hypothermia_alarm = res_s2.flags[hrqa_pkg::FlagHypothermia];
	assign result.no_pulse_alarm    = res_s2.flags[hrqa_pkg::FlagNoPulse];

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.heart_rate != '0) |->
		(result.heart_rate >= 8'd25) && (result.heart_rate <= 8'd220))
		else $error("smoothed heart rate outside the qualified range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=>
		result.valid && $stable(result.heart_rate) && $stable(result.temp_tenths))
		else $error("waiting result beat changed before it was taken");

	a_spo2_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.spo2_value != hrqa_pkg::Spo2None) |->
		(result.spo2_value >= hrqa_pkg::Spo2Min) && (result.spo2_value <= hrqa_pkg::Spo2Max))
		else $error("held SpO2 is neither invalid nor in range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		(result.temp_tenths >= hrqa_pkg::TempBase) && (result.temp_tenths <= hrqa_pkg::TempTop))
		else $error("temperature outside the scaled range");

endmodule

@@ sim/vitals_monitor.sv @@
`timescale 1ns / 1ps
// Monitor for the heart rate qualifier and alarm block: follows register writes, predicts one
// result beat per accepted pulse beat and compares every result field against the prediction.
// Depends on hrqa_pkg and the channel interfaces of hrqa_if.sv.

module vitals_monitor (
	input  logic   clk,
	input  logic   arst_n,
	hrqa_item_if   item,
	hrqa_result_if result,
	hrqa_cfg_if    cfg,
	output int     errors,
	output int     outstanding,
	output int     checked
);
	import hrqa_pkg::*;

	cfg_t                    regs;
	logic [RateW-1:0]        cand_bpm;
	logic [CntW-1:0]         agree_cnt;
	logic [RateW-1:0]        avg_bpm;
	logic signed [BpmW-1:0]  last_reading;
	logic [TimeW-1:0]        pulse_seen_ms;
	logic [TimeW-1:0]        crit_since_ms;
	logic                    crit_held;
	logic [TimeW-1:0]        eval_due_ms;
	logic [TimeW-1:0]        buzz_flip_ms;
	logic                    buzz_phase;
	logic                    buzz_pin;
	logic signed [Spo2W-1:0] spo2_hold;
	logic [TempW-1:0]        temp_hold;
	logic [FlagW-1:0]        vitals_flags;

	result_t expected_vitals[$];
	item_t   beat;
	result_t want;
	result_t predicted;

	task automatic clear_vitals();
		regs.bpm_tolerance            = RstBpmTol;
		regs.confirmations_needed     = RstConfirm;
		regs.brady_limit              = RstBrady;
		regs.tachy_limit              = RstTachy;
		regs.hypoxia_limit            = RstHypoxia;
		regs.fever_limit_tenths       = RstFever;
		regs.hypothermia_limit_tenths = RstHypother;
		regs.critical_hold_ms         = RstHold;
		cand_bpm      = '0;
		agree_cnt     = '0;
		avg_bpm       = '0;
		last_reading  = BpmNone;
		pulse_seen_ms = '0;
		crit_since_ms = '0;
		crit_held     = 1'b0;
		eval_due_ms   = '0;
		buzz_flip_ms  = '0;
		buzz_phase    = 1'b0;
		buzz_pin      = 1'b0;
		spo2_hold     = Spo2None;
		temp_hold     = TempReset;
		vitals_flags  = '0;
	endtask

	task automatic advance_vitals(input item_t b, output result_t res);
		int               rd;
		int               lr;
		int               sp;
		int               diff;
		logic [TimeW-1:0] gap;
		logic             out_rng;
		logic             stale;
		logic [FlagW-1:0] f;

		rd = int'(b.bpm_reading);
		last_reading = b.bpm_reading;
		if (rd >= int'(BpmMin) && rd <= int'(BpmMax)) begin
			pulse_seen_ms = b.now_ms;
			diff = (rd > int'(cand_bpm)) ? rd - int'(cand_bpm) : int'(cand_bpm) - rd;
			if (cand_bpm == '0 || diff > int'(regs.bpm_tolerance)) begin
				cand_bpm  = RateW'(rd);
				agree_cnt = 2'd1;
			end else begin
				cand_bpm = RateW'((int'(cand_bpm) * 7 + rd * 3) / 10);
				if (agree_cnt < regs.confirmations_needed) begin
					agree_cnt = agree_cnt + 2'd1;
				end
			end
			if (agree_cnt >= regs.confirmations_needed) begin
				if (avg_bpm == '0) begin
					avg_bpm = cand_bpm;
				end else begin
					avg_bpm = RateW'((int'(avg_bpm) * 8 + int'(cand_bpm) * 2) / 10);
				end
			end
		end

		// Losing the finger wipes the rate history before the evaluation sees it.
		if (!b.finger_present) begin
			avg_bpm       = '0;
			last_reading  = BpmNone;
			cand_bpm      = '0;
			agree_cnt     = '0;
			pulse_seen_ms = '0;
			crit_since_ms = '0;
			crit_held     = 1'b0;
		end

		gap = b.now_ms - eval_due_ms;
		if (gap >= EvalPeriod) begin
			eval_due_ms = eval_due_ms + EvalPeriod;
			sp = int'(b.spo2_reading);
			spo2_hold = (sp >= int'(Spo2Min) && sp <= int'(Spo2Max)) ? b.spo2_reading : Spo2None;
			temp_hold = TempW'(int'(b.temp_adc) * 60 / int'(AdcFull) + int'(TempBase));

			lr = int'(last_reading);
			out_rng = lr >= int'(BpmMin) &&
				(lr < int'(regs.brady_limit) || lr > int'(regs.tachy_limit));
			gap = b.now_ms - pulse_seen_ms;
			stale = b.finger_present && pulse_seen_ms != '0 &&
				gap >= TimeW'(regs.critical_hold_ms);
			if (out_rng || stale) begin
				if (crit_since_ms == '0) begin
					crit_since_ms = b.now_ms;
				end
				gap = b.now_ms - crit_since_ms;
				if (gap >= TimeW'(regs.critical_hold_ms)) begin
					crit_held = 1'b1;
				end
			end else begin
				crit_since_ms = '0;
				crit_held     = 1'b0;
			end

			f = '0;
			f[FlagBrady]       = crit_held && avg_bpm != '0 && avg_bpm < regs.brady_limit;
			f[FlagTachy]       = crit_held && avg_bpm > regs.tachy_limit;
			f[FlagHypoxia]     = int'(spo2_hold) > 0 &&
				int'(spo2_hold) < int'(regs.hypoxia_limit);
			f[FlagFever]       = temp_hold > regs.fever_limit_tenths;
			f[FlagHypothermia] = temp_hold < regs.hypothermia_limit_tenths;
			f[FlagNoPulse]     = b.finger_present && avg_bpm == '0;
			vitals_flags = f;

			if (f != '0) begin
				gap = b.now_ms - buzz_flip_ms;
				if (gap > ToggleGap) begin
					buzz_phase   = !buzz_phase;
					buzz_pin     = buzz_phase;
					buzz_flip_ms = b.now_ms;
				end
			end else begin
				buzz_pin = 1'b0;
			end
		end

		res.heart_rate     = avg_bpm;
		res.spo2_value     = spo2_hold;
		res.temp_tenths    = temp_hold;
		res.buzzer_on      = buzz_pin;
		res.rate_confirmed = crit_held;
		res.flags          = vitals_flags;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_vitals();
			expected_vitals.delete();
			errors      = 0;
			outstanding = 0;
			checked     = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_BPM_TOL:     regs.bpm_tolerance            = RateW'(cfg.data);
					CFG_CONFIRM:     regs.confirmations_needed     = CntW'(cfg.data);
					CFG_BRADY:       regs.brady_limit              = RateW'(cfg.data);
					CFG_TACHY:       regs.tachy_limit              = RateW'(cfg.data);
					CFG_HYPOXIA:     regs.hypoxia_limit            = Spo2LimW'(cfg.data);
					CFG_FEVER:       regs.fever_limit_tenths       = TempW'(cfg.data);
					CFG_HYPOTHERMIA: regs.hypothermia_limit_tenths = TempW'(cfg.data);
					default:         regs.critical_hold_ms         = HoldW'(cfg.data);
				endcase
			end

			if (item.valid && item.ready) begin
				beat.now_ms         = item.now_ms;
				beat.bpm_reading    = item.bpm_reading;
				beat.finger_present = item.finger_present;
				beat.spo2_reading   = item.spo2_reading;
				beat.temp_adc       = item.temp_adc;
				advance_vitals(beat, predicted);
				expected_vitals.push_back(predicted);
			end

			if (result.valid && result.ready) begin
				if (expected_vitals.size() == 0) begin
					$error("result beat arrived with no pulse beat waiting for it");
					errors++;
				end else begin
					want = expected_vitals.pop_front();
					check_field("heart_rate", int'(want.heart_rate), int'(result.heart_rate));
					check_field("spo2_value", int'(want.spo2_value),
						int'(result.spo2_value));
					check_field("temp_tenths", int'(want.temp_tenths),
						int'(result.temp_tenths));
					check_field("buzzer_on", int'(want.buzzer_on), int'(result.buzzer_on));
					check_field("rate_confirmed", int'(want.rate_confirmed),
						int'(result.rate_confirmed));
					check_field("brady_alarm", int'(want.flags[FlagBrady]),
						int'(result.brady_alarm));
					check_field("tachy_alarm", int'(want.flags[FlagTachy]),
						int'(result.tachy_alarm));
					check_field("hypoxia_alarm", int'(want.flags[FlagHypoxia]),
						int'(result.hypoxia_alarm));
					check_field("fever_alarm", int'(want.flags[FlagFever]),
						int'(result.fever_alarm));
					check_field("hypothermia_alarm", int'(want.flags[FlagHypothermia]),
						int'(result.hypothermia_alarm));
					check_field("no_pulse_alarm", int'(want.flags[FlagNoPulse]),
						int'(result.no_pulse_alarm));
					checked++;
				end
			end

			outstanding = expected_vitals.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the simulation: drives pulse beats, register writes and result back-pressure into the
// heart rate qualifier and alarm block and gives the verdict from the monitor's error count.
// Depends on hrqa_pkg, hrqa_if.sv, the block itself and vitals_monitor.

module testbench;
	import hrqa_pkg::*;

	localparam int NumPhases     = 6;
	localparam int PhaseItems    = 240;
	localparam int HoldOffCycles = 300;
	localparam int IdlePct       = 19;
	localparam int CycleLimit    = 400000;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   sent;
	int   errors;
	int   outstanding;
	int   checked;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_off_req;

	logic [TimeW-1:0] t_ms;
	int               base_bpm;
	int               absent_left;
	int               dropout_left;
	item_t            pulse;

	hrqa_item_if   item_ch ();
	hrqa_result_if result_ch ();
	hrqa_cfg_if    cfg_ch ();

	heart_rate_qualifier_alarm uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	vitals_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result back-pressure, including one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HoldOffCycles - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic push_beat(input item_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.now_ms         <= b.now_ms;
		item_ch.bpm_reading    <= b.bpm_reading;
		item_ch.finger_present <= b.finger_present;
		item_ch.spo2_reading   <= b.spo2_reading;
		item_ch.temp_adc       <= b.temp_adc;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic direct_beat(input logic [TimeW-1:0] now, input int bpm, input int fin,
		input int sp, input int adc);
		item_t b;
		b.now_ms         = now;
		b.bpm_reading    = BpmW'(bpm);
		b.finger_present = 1'(fin);
		b.spo2_reading   = Spo2W'(sp);
		b.temp_adc       = AdcW'(adc);
		push_beat(b);
	endtask

	// Mostly a plausible monitoring session: steady time, a wandering base rate with jitter,
	// finger losses and pulse dropouts, plus a few beats of pure noise.
	task automatic make_pulse(output item_t b);
		int roll;
		int rd;
		int spread;
		if ($urandom_range(99) < 3) begin
			b.now_ms         = $urandom;
			b.bpm_reading    = BpmW'(int'($urandom_range(256)) - 1);
			b.finger_present = 1'($urandom_range(1));
			b.spo2_reading   = Spo2W'(int'($urandom_range(128)) - 1);
			b.temp_adc       = AdcW'($urandom_range(4095));
			t_ms = t_ms + 20;
		end else begin
			if ($urandom_range(99) < 2) begin
				t_ms = t_ms + $urandom_range(120, 20);
			end else begin
				t_ms = t_ms + $urandom_range(15);
			end
			if (absent_left == 0 && $urandom_range(199) < 3) begin
				absent_left = $urandom_range(15, 1);
			end
			if (dropout_left == 0 && $urandom_range(99) < 2) begin
				dropout_left = $urandom_range(40, 5);
			end
			if ($urandom_range(99) < 2) begin
				case ($urandom_range(3))
					0:       base_bpm = $urandom_range(49, 25);
					1:       base_bpm = $urandom_range(120, 50);
					2:       base_bpm = $urandom_range(220, 121);
					default: base_bpm = $urandom_range(230, 20);
				endcase
			end
			roll = $urandom_range(99);
			if (dropout_left > 0) begin
				dropout_left--;
				rd = (roll < 90) ? -1 : int'($urandom_range(24));
			end else if (roll < 85) begin
				spread = $urandom_range(12);
				rd = base_bpm + int'($urandom_range(2 * spread)) - spread;
				if (rd < 0) begin
					rd = 0;
				end else if (rd > 255) begin
					rd = 255;
				end
			end else if (roll < 93) begin
				rd = -1;
			end else begin
				rd = int'($urandom_range(256)) - 1;
			end
			b.now_ms         = t_ms;
			b.bpm_reading    = BpmW'(rd);
			b.finger_present = (absent_left == 0);
			if (absent_left > 0) begin
				absent_left--;
			end
			roll = $urandom_range(99);
			if (roll < 75) begin
				b.spo2_reading = Spo2W'($urandom_range(100, 60));
			end else if (roll < 85) begin
				b.spo2_reading = Spo2None;
			end else begin
				b.spo2_reading = Spo2W'(int'($urandom_range(128)) - 1);
			end
			b.temp_adc = AdcW'($urandom_range(4095));
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CfgDataW'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int phase);
		int v [8];
		case (phase)
			1: v = '{0, 1, 255, 0, 100, 340, 400, 0};
			2: v = '{255, 3, 0, 255, 0, 400, 340, 65535};
			3: v = '{8, 0, 60, 100, 95, 375, 350, 40};
			default: begin
				v[0] = $urandom_range(30);
				v[1] = $urandom_range(3);
				v[2] = $urandom_range(90, 25);
				v[3] = $urandom_range(220, 90);
				v[4] = $urandom_range(100);
				v[5] = $urandom_range(400, 340);
				v[6] = $urandom_range(400, 340);
				v[7] = $urandom_range(400);
			end
		endcase
		write_reg(CFG_BPM_TOL, v[0]);
		write_reg(CFG_CONFIRM, v[1]);
		write_reg(CFG_BRADY, v[2]);
		write_reg(CFG_TACHY, v[3]);
		write_reg(CFG_HYPOXIA, v[4]);
		write_reg(CFG_FEVER, v[5]);
		write_reg(CFG_HYPOTHERMIA, v[6]);
		write_reg(CFG_HOLD, v[7]);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.now_ms         = '0;
		item_ch.bpm_reading    = '0;
		item_ch.finger_present = 1'b0;
		item_ch.spo2_reading   = '0;
		item_ch.temp_adc       = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = '0;
		cfg_ch.data            = '0;
		hold_off_req           = 1'b0;
		send_idle_pct          = IdlePct;
		recv_idle_pct          = IdlePct;
		sent                   = 0;
		t_ms                   = '0;
		base_bpm               = 72;
		absent_left            = 0;
		dropout_left           = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A valid reading at time zero leaves no trace of a last valid time.
		direct_beat(0, 80, 1, 98, 2048);
		direct_beat(4, 82, 1, 97, 2048);
		direct_beat(9, 81, 1, 96, 2048);
		direct_beat(10, 83, 1, 70, 0);
		direct_beat(15, 25, 1, 100, 4095);
		direct_beat(20, 220, 1, 101, 4095);
		direct_beat(26, 221, 1, 69, 1);
		direct_beat(30, 24, 1, -1, 4094);
		direct_beat(35, -1, 1, 127, 2730);
		direct_beat(40, 255, 1, 0, 1365);
		direct_beat(41, 100, 0, 95, 2048);
		direct_beat(50, 100, 1, 95, 2048);
		direct_beat(50, 100, 1, 95, 2048);
		direct_beat(60, 101, 1, 80, 3000);
		direct_beat(70, 99, 1, 85, 3900);
		direct_beat(32'hFFFF_FFFF, 100, 1, 90, 4095);
		direct_beat(32'hAAAA_AAAA, 100, 1, 90, 2730);
		direct_beat(32'h5555_5555, 100, 1, 90, 1365);
		direct_beat(160, 60, 1, 91, 0);
		direct_beat(170, 60, 1, 91, 0);
		direct_beat(330, 100, 1, 99, 2048);
		direct_beat(340, -1, 1, 99, 2048);
		t_ms = 360;

		for (int p = 0; p < NumPhases; p++) begin
			if (p > 0) begin
				drain();
				apply_setting(p);
			end
			send_idle_pct = (p == 1) ? 0 : IdlePct;
			recv_idle_pct = (p == 1) ? 0 : IdlePct;
			for (int i = 0; i < PhaseItems; i++) begin
				if (i == 60 && (p == 2 || p == 4)) begin
					hold_off_req = 1'b1;
				end
				make_pulse(pulse);
				push_beat(pulse);
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Checked %0d result beats from %0d pulse beats over %0d register settings,",
			checked, sent, NumPhases);
		$display("with finger losses, pulse dropouts, timestamp extremes and a long stall.");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/hrqa_pkg.sv
hdl/hrqa_if.sv
hdl/hrqa_cfg_regs.sv
hdl/hrqa_core.sv
hdl/heart_rate_qualifier_alarm.sv
sim/vitals_monitor.sv
sim/testbench.sv
